/* src/autorange_capacitance_meter_macros.svh */
// Assertion helpers used by the checker file.
`ifndef AUTORANGE_CAPACITANCE_METER_MACROS_SVH
`define AUTORANGE_CAPACITANCE_METER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet while reset is low.
`define ACM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while reset is low.
`define ACM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/acm_pkg.sv */
package acm_pkg;

    localparam int NUM_RANGES = 9;
    localparam int RANGE_W    = 4;
    localparam int CAP_W      = 16;
    localparam int SCALE_W    = 44;
    localparam int FF_W       = 44;
    localparam int LIMIT_W    = 30;
    localparam int CODE_W     = 3;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = CAP_W + SCALE_W;

    localparam logic [RANGE_W-1:0] LAST_RANGE  = RANGE_W'(NUM_RANGES - 1);
    localparam logic [RANGE_W-1:0] RESET_RANGE =
        (NUM_RANGES > 4) ? RANGE_W'(4) : LAST_RANGE;

    localparam logic [CAP_W-1:0]   OVF_CAPTURE   = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] ZERO_LIMIT_RST = 30'd100000;

    // Timer clock select codes
    localparam logic [CODE_W-1:0] CS_DIV1    = 3'd1;
    localparam logic [CODE_W-1:0] CS_DIV8    = 3'd2;
    localparam logic [CODE_W-1:0] CS_DIV64   = 3'd3;
    localparam logic [CODE_W-1:0] CS_DIV256  = 3'd4;
    localparam logic [CODE_W-1:0] CS_DIV1024 = 3'd5;

    // One-hot drive resistor selects
    localparam logic [CODE_W-1:0] DRV_LOW  = 3'd1;
    localparam logic [CODE_W-1:0] DRV_MID  = 3'd2;
    localparam logic [CODE_W-1:0] DRV_HIGH = 3'd4;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;      // fF per tick, 28.16
        logic [CAP_W-1:0]   threshold;  // step up below this capture
        logic [CODE_W-1:0]  clk_code;
        logic [CODE_W-1:0]  drv_code;
    } t_range_desc;

    typedef struct packed {
        logic [RANGE_W-1:0] cur;
        logic               ovf;
        logic [FF_W-1:0]    raw;
        logic [RANGE_W-1:0] nxt;
        logic [CODE_W-1:0]  clk_code;
        logic [CODE_W-1:0]  drv_code;
    } t_conv;

    typedef struct packed {
        logic [RANGE_W-1:0] range_used;
        logic               over_range;
        logic [FF_W-1:0]    capacitance_ff;
        logic               zero_taken;
        logic [RANGE_W-1:0] next_range;
        logic [CODE_W-1:0]  next_prescale_code;
        logic [CODE_W-1:0]  next_resistor_code;
    } t_result;

    // Ranges past the table reuse the last entry.
    function automatic t_range_desc desc_of(input logic [RANGE_W-1:0] r);
        t_range_desc d;
        unique case (r)
            4'd0:    d = '{44'd10259673725906, 16'd16384, CS_DIV1024, DRV_LOW};
            4'd1:    d = '{44'd2564918431477,  16'd16384, CS_DIV256,  DRV_LOW};
            4'd2:    d = '{44'd641229607869,   16'd8192,  CS_DIV64,   DRV_LOW};
            4'd3:    d = '{44'd80153700984,    16'd8192,  CS_DIV8,    DRV_LOW};
            4'd4:    d = '{44'd10019212623,    16'd14156, CS_DIV1,    DRV_LOW};
            4'd5:    d = '{44'd2164149927,     16'd8192,  CS_DIV8,    DRV_MID};
            4'd6:    d = '{44'd270518741,      16'd5243,  CS_DIV1,    DRV_MID};
            4'd7:    d = '{44'd21641499,       16'd8192,  CS_DIV8,    DRV_HIGH};
            default: d = '{44'd2705187,        16'd0,     CS_DIV1,    DRV_HIGH};
        endcase
        return d;
    endfunction

endpackage

/* src/acm_convert.sv */
module acm_convert (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [acm_pkg::CAP_W-1:0]     i_cap,
    output acm_pkg::t_conv                o_conv
);

    logic [acm_pkg::RANGE_W-1:0] r_range;
    logic [acm_pkg::RANGE_W-1:0] n_range;
    acm_pkg::t_range_desc        cur_desc;
    acm_pkg::t_range_desc        nxt_desc;
    logic [acm_pkg::PROD_W-1:0]  prod;
    logic                        ovf;

    assign cur_desc = acm_pkg::desc_of(r_range);
    assign ovf      = (i_cap == acm_pkg::OVF_CAPTURE);
    assign prod     = {{acm_pkg::SCALE_W{1'b0}}, i_cap}
                    * {{acm_pkg::CAP_W{1'b0}}, cur_desc.scale};

    // Step down on overflow, up on a short capture, otherwise hold.
    always_comb begin
        n_range = r_range;
        priority if (ovf) begin
            if (r_range != '0) n_range = r_range - 1'b1;
        end else if (i_cap < cur_desc.threshold && r_range < acm_pkg::LAST_RANGE) begin
            n_range = r_range + 1'b1;
        end else begin
            n_range = r_range;
        end
    end

    assign nxt_desc = acm_pkg::desc_of(n_range);

    always_comb begin
        o_conv.cur      = r_range;
        o_conv.ovf      = ovf;
        o_conv.raw      = prod[acm_pkg::PROD_W-1:acm_pkg::FRAC_W];
        o_conv.nxt      = n_range;
        o_conv.clk_code = nxt_desc.clk_code;
        o_conv.drv_code = nxt_desc.drv_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= acm_pkg::RESET_RANGE;
        end else if (i_adv) begin
            r_range <= n_range;
        end
    end

endmodule

/* src/acm_zero.sv */
module acm_zero (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [acm_pkg::LIMIT_W-1:0]   i_zero_limit,
    input  acm_pkg::t_conv                i_conv,
    output acm_pkg::t_result              o_res
);

    logic                       r_zero_done;
    logic [acm_pkg::FF_W-1:0]   r_zero_offset;
    logic                       took;
    logic                       done_eff;
    logic [acm_pkg::FF_W-1:0]   offset_eff;
    logic [acm_pkg::FF_W-1:0]   corrected;

    assign took = !r_zero_done && (i_conv.cur == acm_pkg::LAST_RANGE)
               && (i_conv.raw < {{(acm_pkg::FF_W-acm_pkg::LIMIT_W){1'b0}}, i_zero_limit});
    assign done_eff   = r_zero_done || took;
    assign offset_eff = took ? i_conv.raw : r_zero_offset;

    // Subtract the offset and clamp at zero.
    always_comb begin
        if (!done_eff) begin
            corrected = i_conv.raw;
        end else if (i_conv.raw > offset_eff) begin
            corrected = i_conv.raw - offset_eff;
        end else begin
            corrected = '0;
        end
    end

    always_comb begin
        o_res.range_used         = i_conv.cur;
        o_res.over_range         = i_conv.ovf;
        o_res.capacitance_ff     = corrected;
        o_res.zero_taken         = took;
        o_res.next_range         = i_conv.nxt;
        o_res.next_prescale_code = i_conv.clk_code;
        o_res.next_resistor_code = i_conv.drv_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_done <= 1'b0;
        end else if (i_adv && took) begin
            r_zero_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
        end else if (i_adv && took) begin
            r_zero_offset <= i_conv.raw;
        end
    end

endmodule

/* src/autorange_capacitance_meter.sv */
// Auto-ranging RC charge-time capacitance meter.
// Slave stream: one 16-bit charge-time capture per transfer in s_tdata[15:0];
// 0xFFFF marks a timer overflow. Master stream: one result per capture.
// Config channel: zero limit in femtofarads, taken whenever cfg_valid is high;
// write it only while no capture is in flight.
// Each capture is scaled by a per-range constant, the first slowest-range
// reading below the zero limit is kept as offset, and the next range with its
// prescale and resistor codes is reported for the front end.
// Path: each capture passes the input register, the multiply stage and the
// result register before m_tvalid rises; the result transfers once m_tready
// is high. Throughput: one capture per cycle while m_tready is high; the
// range register closes its loop inside the multiply stage, the zero offset
// inside the result stage, so back-to-back captures never wait on each other.
// Reset: range 4 (or the last range when there are fewer), no zero offset,
// zero limit 100000 fF, pipeline empty.
// Stall: when m_tready is low the result holds on the port; the two stages
// behind it still fill, and s_tready drops only once all three are full.
module autorange_capacitance_meter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // capture input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] capture_count
    // result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [3:0] range_used, [47:4] capacitance_ff,
                                     // [51:48] next_range, [54:52] next_prescale_code,
                                     // [57:55] next_resistor_code, [63:58] zero
    output logic [1:0]  o_m_tuser,   // [0] over_range, [1] zero_taken
    // zero limit write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [29:0] i_cfg_wdata
);

    logic                           r_in_valid;
    logic [acm_pkg::CAP_W-1:0]      r_in_cap;
    logic                           r_mid_valid;
    acm_pkg::t_conv                 r_mid;
    logic                           r_out_valid;
    acm_pkg::t_result               r_out;
    logic [acm_pkg::LIMIT_W-1:0]    r_zero_limit;

    acm_pkg::t_conv                 conv;
    acm_pkg::t_result               res;
    logic                           out_free;
    logic                           adv_out;
    logic                           mid_free;
    logic                           adv_mid;
    logic                           in_free;
    logic                           in_xfer;

    // Ready ripples back from the output: a stage may load when it is empty
    // or when its content moves on in the same cycle.
    assign out_free = !r_out_valid || i_m_tready;
    assign adv_out  = r_mid_valid && out_free;
    assign mid_free = !r_mid_valid || adv_out;
    assign adv_mid  = r_in_valid && mid_free;
    assign in_free  = !r_in_valid || adv_mid;
    assign in_xfer  = i_s_tvalid && in_free;

    assign o_s_tready  = in_free;
    assign o_cfg_ready = 1'b1;

    acm_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_mid),
        .i_cap   (r_in_cap),
        .o_conv  (conv)
    );

    acm_zero u_zero (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv_out),
        .i_zero_limit (r_zero_limit),
        .i_conv       (r_mid),
        .o_res        (res)
    );

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free)  r_in_valid  <= i_s_tvalid;
            if (mid_free) r_mid_valid <= r_in_valid;
            if (out_free) r_out_valid <= r_mid_valid;
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_xfer) r_in_cap <= i_s_tdata;
        if (adv_mid) r_mid    <= conv;
        if (adv_out) r_out    <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_limit <= acm_pkg::ZERO_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_zero_limit <= i_cfg_wdata;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0,
                         r_out.next_resistor_code,
                         r_out.next_prescale_code,
                         r_out.next_range,
                         r_out.capacitance_ff,
                         r_out.range_used};
    assign o_m_tuser  = {r_out.zero_taken, r_out.over_range};

endmodule

/* src/acm_checker.sv */
`include "autorange_capacitance_meter_macros.svh"

module acm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    logic [acm_pkg::RANGE_W-1:0] r_expect_range;

    // Track the range announced by the last delivered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_range <= acm_pkg::RESET_RANGE;
        end else if (o_m_tvalid && i_m_tready) begin
            r_expect_range <= o_m_tdata[51:48];
        end
    end

    `ACM_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    `ACM_ASSERT_NOW(a_range_chain, o_m_tvalid, o_m_tdata[3:0] == r_expect_range, "range_used differs from the previous next_range")

    `ACM_ASSERT_NOW(a_ovf_step_down, o_m_tvalid && o_m_tuser[0] && o_m_tdata[3:0] != 4'd0, o_m_tdata[51:48] == o_m_tdata[3:0] - 4'd1, "overflow did not step the range down")

    `ACM_ASSERT_NOW(a_zero_result, o_m_tvalid && o_m_tuser[1], o_m_tdata[47:4] == 44'd0 && o_m_tdata[3:0] == acm_pkg::LAST_RANGE, "zeroing result not zero or not on slowest range")

endmodule

bind autorange_capacitance_meter acm_checker u_acm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Timer clock of the front end; the range scales are derived from it.
    localparam longint unsigned TIMER_HZ = 64'd16000000;
    // ln(5/1.1) = 1.514128, divided by 16 so it pairs with 4096 instead of 65536.
    localparam longint unsigned LN_RATIO_DIV16 = 64'd94633;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS = 143;

    // One row of the range table: drive resistor, prescaler, codes, step-up threshold.
    typedef struct packed {
        logic [19:0]                ohms;
        logic [10:0]                prescale;
        logic [acm_pkg::CODE_W-1:0] clk_code;
        logic [acm_pkg::CODE_W-1:0] drv_code;
        logic [acm_pkg::CAP_W-1:0]  step_up_below;
    } t_range_row;

    // Directed stimulus: capture, whether the result is typed in, and that result.
    typedef struct packed {
        logic [acm_pkg::CAP_W-1:0]  capture;
        logic                       known;
        acm_pkg::t_result           want;
    } t_row;

    localparam acm_pkg::t_result NO_WANT = '0;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [15:0]        i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [63:0]        o_m_tdata;
    logic [1:0]         o_m_tuser;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [29:0]        i_cfg_wdata;

    autorange_capacitance_meter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predictor state: mirrors the meter's range, zero offset and zero limit.
    logic [acm_pkg::RANGE_W-1:0] meter_range = acm_pkg::RESET_RANGE;
    logic                        zero_held = 1'b0;
    logic [acm_pkg::FF_W-1:0]    zero_base_ff = '0;
    logic [acm_pkg::LIMIT_W-1:0] zero_limit = acm_pkg::ZERO_LIMIT_RST;

    acm_pkg::t_result   pending_readings[$];
    int                 bad_readings = 0;

    // Typed-in expectation for the capture currently offered, if any.
    logic               row_known = 1'b0;
    acm_pkg::t_result   row_want = NO_WANT;

    bit                 source_steady = 1'b0;
    bit                 sink_steady = 1'b0;

    t_row               plan [26];
    int                 phase_limit [RANDOM_PHASES];

    always #1 i_clk = ~i_clk;

    function automatic t_range_row range_row(input logic [acm_pkg::RANGE_W-1:0] r);
        case (r)
            4'd0: return '{20'd270, 11'd1024, acm_pkg::CS_DIV1024, acm_pkg::DRV_LOW, 16'd16384};
            4'd1: return '{20'd270, 11'd256, acm_pkg::CS_DIV256, acm_pkg::DRV_LOW, 16'd16384};
            4'd2: return '{20'd270, 11'd64, acm_pkg::CS_DIV64, acm_pkg::DRV_LOW, 16'd8192};
            4'd3: return '{20'd270, 11'd8, acm_pkg::CS_DIV8, acm_pkg::DRV_LOW, 16'd8192};
            4'd4: return '{20'd270, 11'd1, acm_pkg::CS_DIV1, acm_pkg::DRV_LOW, 16'd14156};
            4'd5: return '{20'd10000, 11'd8, acm_pkg::CS_DIV8, acm_pkg::DRV_MID, 16'd8192};
            4'd6: return '{20'd10000, 11'd1, acm_pkg::CS_DIV1, acm_pkg::DRV_MID, 16'd5243};
            4'd7: return '{20'd1000000, 11'd8, acm_pkg::CS_DIV8, acm_pkg::DRV_HIGH, 16'd8192};
            // ranges past the table reuse the slowest one
            default: return '{20'd1000000, 11'd1, acm_pkg::CS_DIV1, acm_pkg::DRV_HIGH, 16'd0};
        endcase
    endfunction

    // Femtofarads per timer tick in 28.16, rounded half up, from the RC formula.
    function automatic logic [acm_pkg::FF_W-1:0] ff_per_tick(
        input logic [acm_pkg::RANGE_W-1:0] r);
        t_range_row d;
        logic [127:0] num;
        logic [127:0] den;
        d = range_row(r);
        num = 128'(d.prescale) * 128'd4096 * 128'd1000000000 * 128'd1000000000000;
        den = 128'(TIMER_HZ) * 128'(d.ohms) * 128'(LN_RATIO_DIV16);
        return acm_pkg::FF_W'((num + (den >> 1)) / den);
    endfunction

    // Convert one capture on the current range, apply zeroing and step the range.
    function automatic acm_pkg::t_result predict_reading(
        input logic [acm_pkg::CAP_W-1:0] cap);
        acm_pkg::t_result            r;
        logic [acm_pkg::PROD_W-1:0]  prod;
        logic [acm_pkg::FF_W-1:0]    raw;
        logic [acm_pkg::RANGE_W-1:0] cur;
        logic [acm_pkg::RANGE_W-1:0] nxt;
        logic                        took;
        t_range_row                  cd;
        t_range_row                  nd;
        cur = meter_range;
        cd = range_row(cur);
        prod = acm_pkg::PROD_W'(cap) * acm_pkg::PROD_W'(ff_per_tick(cur));
        raw = prod[acm_pkg::PROD_W-1:acm_pkg::FRAC_W];
        took = 1'b0;
        if (!zero_held && cur == acm_pkg::LAST_RANGE
            && raw < acm_pkg::FF_W'(zero_limit)) begin
            zero_base_ff = raw;
            zero_held = 1'b1;
            took = 1'b1;
        end
        if (zero_held)
            raw = (raw > zero_base_ff) ? raw - zero_base_ff : '0;
        nxt = cur;
        if (cap == acm_pkg::OVF_CAPTURE) begin
            if (nxt != 0)
                nxt = nxt - 1'b1;
        end else if (cap < cd.step_up_below && nxt < acm_pkg::LAST_RANGE) begin
            nxt = nxt + 1'b1;
        end
        meter_range = nxt;
        nd = range_row(nxt);
        r.range_used = cur;
        r.over_range = (cap == acm_pkg::OVF_CAPTURE);
        r.capacitance_ff = raw;
        r.zero_taken = took;
        r.next_range = nxt;
        r.next_prescale_code = nd.clk_code;
        r.next_resistor_code = nd.drv_code;
        return r;
    endfunction

    // Pick a capture that moves the meter around: overflows, step-ups,
    // values at the threshold edge, tiny readings and anything at all.
    function automatic logic [acm_pkg::CAP_W-1:0] draw_capture();
        logic [acm_pkg::CAP_W-1:0] thr;
        int                        kind;
        thr = range_row(meter_range).step_up_below;
        kind = $urandom_range(0, 19);
        if (kind < 3)
            return acm_pkg::OVF_CAPTURE;
        if (kind < 7 && thr != 0)
            return acm_pkg::CAP_W'($urandom_range(0, int'(thr) - 1));
        if (kind < 10 && thr != 0)
            return acm_pkg::CAP_W'($urandom_range(thr >= 2 ? int'(thr) - 2 : 0,
                                                  int'(thr) + 1));
        if (kind < 12)
            return acm_pkg::CAP_W'($urandom_range(0, 15));
        return acm_pkg::CAP_W'($urandom_range(0, 65534));
    endfunction

    task automatic note_bad(input string what, input acm_pkg::t_result want,
                            input acm_pkg::t_result got);
        bad_readings++;
        if (bad_readings <= MAX_REPORTS)
            $display("%0t: %s: want rng=%0d ovf=%0d cap=%0d zero=%0d nxt=%0d ps=%0d rs=%0d",
                     $time, what,
                     want.range_used, want.over_range, want.capacitance_ff, want.zero_taken,
                     want.next_range, want.next_prescale_code, want.next_resistor_code,
                     " | got rng=%0d ovf=%0d cap=%0d zero=%0d nxt=%0d ps=%0d rs=%0d pad=%0h",
                     got.range_used, got.over_range, got.capacitance_ff, got.zero_taken,
                     got.next_range, got.next_prescale_code, got.next_resistor_code,
                     o_m_tdata[63:58]);
    endtask

    // Sample every transfer at the rising edge: track the limit, predict
    // each accepted capture and compare each result with the oldest one.
    always @(posedge i_clk) begin
        acm_pkg::t_result want;
        acm_pkg::t_result got;
        bit               same;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                zero_limit = i_cfg_wdata;
            if (i_s_tvalid && o_s_tready) begin
                want = predict_reading(i_s_tdata);
                if (row_known)
                    want = row_want;
                pending_readings.push_back(want);
            end
            if (o_m_tvalid && i_m_tready) begin
                got.range_used = o_m_tdata[3:0];
                got.over_range = o_m_tuser[0];
                got.capacitance_ff = o_m_tdata[47:4];
                got.zero_taken = o_m_tuser[1];
                got.next_range = o_m_tdata[51:48];
                got.next_prescale_code = o_m_tdata[54:52];
                got.next_resistor_code = o_m_tdata[57:55];
                if (pending_readings.size() == 0) begin
                    note_bad("result with nothing pending", NO_WANT, got);
                end else begin
                    want = pending_readings.pop_front();
                    same = (got.range_used === want.range_used)
                        && (got.over_range === want.over_range)
                        && (got.capacitance_ff === want.capacitance_ff)
                        && (got.zero_taken === want.zero_taken)
                        && (got.next_range === want.next_range)
                        && (got.next_prescale_code === want.next_prescale_code)
                        && (got.next_resistor_code === want.next_resistor_code)
                        && (o_m_tdata[63:58] === 6'd0);
                    if (!same)
                        note_bad("reading mismatch", want, got);
                end
            end
        end
    end

    // Offer one capture after a gap; return at the falling edge after its transfer.
    task automatic send_capture(input logic [acm_pkg::CAP_W-1:0] cap, input int gap,
                                input logic known, input acm_pkg::t_result want);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_known = known;
        row_want = want;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= cap;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Hold off captures until every pending result has come out, then let
    // the pipeline settle so the meter is idle.
    task automatic drain_meter();
        i_s_tvalid <= 1'b0;
        row_known = 1'b0;
        while (pending_readings.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_zero_limit(input logic [acm_pkg::LIMIT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_wdata <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: stall a random number of cycles before each transfer,
    // or none at all while sink_steady is set.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            n = sink_steady ? 0 : $urandom_range(0, 19);
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_wdata = '0;

        // Directed walk: zero readings climb from the reset range to the
        // slowest one, overflows descend to range 0 and stick there, then
        // captures just under each threshold, some just at it, climb back up.
        plan = '{
            '{16'd0, 1'b1, '{4'd4, 1'b0, 44'd0, 1'b0, 4'd5, acm_pkg::CS_DIV8, acm_pkg::DRV_MID}},
            '{16'd0, 1'b1, '{4'd5, 1'b0, 44'd0, 1'b0, 4'd6, acm_pkg::CS_DIV1, acm_pkg::DRV_MID}},
            '{16'd0, 1'b1, '{4'd6, 1'b0, 44'd0, 1'b0, 4'd7, acm_pkg::CS_DIV8, acm_pkg::DRV_HIGH}},
            '{16'd0, 1'b1, '{4'd7, 1'b0, 44'd0, 1'b0, 4'd8, acm_pkg::CS_DIV1, acm_pkg::DRV_HIGH}},
            '{16'd0, 1'b1, '{4'd8, 1'b0, 44'd0, 1'b0, 4'd8, acm_pkg::CS_DIV1, acm_pkg::DRV_HIGH}},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'hFFFF,  1'b0, NO_WANT},
            '{16'd16384, 1'b0, NO_WANT},
            '{16'd16383, 1'b0, NO_WANT},
            '{16'd16383, 1'b0, NO_WANT},
            '{16'd8192,  1'b0, NO_WANT},
            '{16'd8191,  1'b0, NO_WANT},
            '{16'd65534, 1'b0, NO_WANT},
            '{16'd8191,  1'b0, NO_WANT},
            '{16'd14155, 1'b0, NO_WANT},
            '{16'd8191,  1'b0, NO_WANT},
            '{16'd5242,  1'b0, NO_WANT},
            '{16'd8191,  1'b0, NO_WANT},
            '{16'd65534, 1'b0, NO_WANT}
        };

        // Limits per random phase: the zero offset is taken at most once,
        // in the first phase whose limit lets a slowest-range reading in.
        phase_limit = '{0, 0, 1, 1000000000, 0, 0, 100000};
        phase_limit[1] = $urandom_range(0, 1000000000);
        phase_limit[5] = $urandom_range(0, 1000000000);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Keep zeroing off through the directed walk.
        write_zero_limit('0);
        foreach (plan[i])
            send_capture(plan[i].capture, $urandom_range(0, 19), plan[i].known, plan[i].want);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_meter();
            write_zero_limit(acm_pkg::LIMIT_W'(phase_limit[p]));
            source_steady = (p % 3 == 1);
            sink_steady = (p % 3 == 2);
            repeat (PHASE_ITEMS)
                send_capture(draw_capture(), source_steady ? 0 : $urandom_range(0, 19),
                             1'b0, NO_WANT);
        end

        drain_meter();
        repeat (10) @(negedge i_clk);
        if (bad_readings == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
